[rtl/core/rsc_pkg.sv]
// Shared types, codes and rate tables for the CPU PLL rate switch controller.
// No dependencies.
`timescale 1ns / 1ps

package rsc_pkg;

   // request commands
   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_RATE  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   // register selects
   localparam logic [1:0] REG_DIV  = 2'd0;
   localparam logic [1:0] REG_CTRL = 2'd1;
   localparam logic [1:0] REG_FREQ = 2'd2;

   // completion status
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT     = 2'd2;
   localparam logic [1:0] STATUS_BUSY        = 2'd3;

   // synthesizer control codes
   localparam logic [18:0] CTRL_PREPARE = 19'd4;
   localparam logic [18:0] CTRL_ENABLE  = 19'd5;

   // post-divider codes
   localparam logic [1:0] DIV_CODE_1 = 2'd0;
   localparam logic [1:0] DIV_CODE_2 = 2'd2;
   localparam logic [1:0] DIV_CODE_4 = 2'd3;

   localparam logic [31:0] FLOOR_DIV_1 = 32'd1000000000;
   localparam logic [31:0] FLOOR_DIV_2 = 32'd500000000;
   localparam logic [31:0] FLOOR_DIV_4 = 32'd250000000;

   localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
   localparam logic [3:0]  FREQ_IDX_RESET = 4'd0;    // 1 GHz entry

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] target_rate_hz;
      logic        lock_seen;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [1:0]  reg_select;
      logic [18:0] write_value;
      logic [30:0] rate_hz;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,   // one answer transaction
      JOB_SET    = 2'd1,   // optional divider write, prepare, N/F word, enable
      JOB_LOCK   = 2'd2    // optional late divider write, then completion
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [30:0] rate;
      logic        div_write;
      logic [1:0]  div_code;
      logic [18:0] freq_word;
   } job_type;

   function automatic logic [18:0] nf_word(input logic [7:0] n, input logic [10:0] f);
      return {n, f};
   endfunction

   function automatic logic [30:0] freq_rate(input logic [3:0] idx);
      case (idx)
         4'd0:    freq_rate = 31'd1000000000;
         4'd1:    freq_rate = 31'd1100000000;
         4'd2:    freq_rate = 31'd1200000000;
         4'd3:    freq_rate = 31'd1300000000;
         4'd4:    freq_rate = 31'd1400000000;
         4'd5:    freq_rate = 31'd1500000000;
         4'd6:    freq_rate = 31'd1600000000;
         4'd7:    freq_rate = 31'd1800000000;
         4'd8:    freq_rate = 31'd1200000000;
         4'd9:    freq_rate = 31'd1300000000;
         4'd10:   freq_rate = 31'd1503000000;
         default: freq_rate = 31'd0;
      endcase
   endfunction

   function automatic logic [18:0] freq_word(input logic [3:0] idx);
      case (idx)
         4'd0:    freq_word = nf_word(8'd34, 11'd75);
         4'd1:    freq_word = nf_word(8'd37, 11'd1517);
         4'd2:    freq_word = nf_word(8'd41, 11'd910);
         4'd3:    freq_word = nf_word(8'd45, 11'd303);
         4'd4:    freq_word = nf_word(8'd48, 11'd1745);
         4'd5:    freq_word = nf_word(8'd52, 11'd1137);
         4'd6:    freq_word = nf_word(8'd56, 11'd531);
         4'd7:    freq_word = nf_word(8'd63, 11'd1365);
         4'd8:    freq_word = nf_word(8'd41, 11'd1024);
         4'd9:    freq_word = nf_word(8'd45, 11'd1024);
         4'd10:   freq_word = nf_word(8'd48, 11'd1744);
         default: freq_word = 19'd0;
      endcase
   endfunction

   // Largest table rate not above the scaled target; duplicates resolve to
   // the lower table index. Scaled target is always at least 1 GHz here.
   function automatic logic [3:0] round_idx(input logic [33:0] scaled);
      if (scaled >= 34'd1800000000)      round_idx = 4'd7;
      else if (scaled >= 34'd1600000000) round_idx = 4'd6;
      else if (scaled >= 34'd1503000000) round_idx = 4'd10;
      else if (scaled >= 34'd1500000000) round_idx = 4'd5;
      else if (scaled >= 34'd1400000000) round_idx = 4'd4;
      else if (scaled >= 34'd1300000000) round_idx = 4'd3;
      else if (scaled >= 34'd1200000000) round_idx = 4'd2;
      else if (scaled >= 34'd1100000000) round_idx = 4'd1;
      else                               round_idx = 4'd0;
   endfunction

endpackage

[rtl/core/cpu_pll_rate_switch_controller.sv]
// CPU PLL rate switch controller, top level: front end, job queue, back end.
// A job is stored in the job queue, then its first result is registered in the result register.
// Throughput: one request per cycle while the job queue has room; the back end emits
// one result per cycle while the receiver takes them (steps as listed in job_op_type).
// Reset (synchronous, active high): idle, timeout 2000 ticks, 1 GHz at divide by one.
// Depends on rsc_pkg, rsc_front, rsc_queue, rsc_back.
`timescale 1ns / 1ps

module cpu_pll_rate_switch_controller #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata
);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_head_valid;
   rsc_pkg::job_type q_job;
   rsc_pkg::job_type q_head;

   rsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   rsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_job   (q_head),
      .head_valid (q_head_valid)
   );

   rsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (q_head),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue overflow");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("job popped from empty queue");

   a_last_write_is_enable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last && rsp_data.result_kind == rsc_pkg::KIND_WRITE)
      |-> (rsp_data.reg_select == rsc_pkg::REG_CTRL &&
           rsp_data.write_value == rsc_pkg::CTRL_ENABLE))
      else $error("final register write is not the enable code");

   a_error_has_no_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != rsc_pkg::STATUS_OK) |-> rsp_data.rate_hz == 31'd0)
      else $error("error result carries a rate");
`endif

endmodule

[rtl/core/rsc_front.sv]
// Front end: accepts request transactions, classifies them, keeps the
// clock state and lock wait, and queues jobs for the back end. Uses rsc_pkg.
`timescale 1ns / 1ps

module rsc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rsc_pkg::req_type req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata,
   input  logic             q_full,
   output logic             q_push,
   output rsc_pkg::job_type q_job
);

   logic [15:0] timeout_ff, timeout_in;
   logic        waiting_ff, waiting_in;
   logic [15:0] wait_count_ff, wait_count_in;
   logic [1:0]  cur_div_ff, cur_div_in;
   logic [3:0]  cur_idx_ff, cur_idx_in;
   logic [1:0]  pend_div_ff, pend_div_in;
   logic        pend_late_ff, pend_late_in;
   logic [30:0] pend_rate_ff, pend_rate_in;

   logic        accept;
   logic        supported;
   logic [1:0]  new_code;
   logic [1:0]  new_shift;
   logic [33:0] scaled;
   logic [3:0]  new_idx;
   logic [30:0] new_rate;
   logic        cur_known;
   logic [1:0]  cur_shift;
   logic [30:0] cur_rate;
   logic [15:0] count_next;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      supported = 1'b1;
      new_code  = rsc_pkg::DIV_CODE_1;
      new_shift = 2'd0;
      if (req_data.target_rate_hz >= rsc_pkg::FLOOR_DIV_1) begin
         new_code  = rsc_pkg::DIV_CODE_1;
         new_shift = 2'd0;
      end else if (req_data.target_rate_hz >= rsc_pkg::FLOOR_DIV_2) begin
         new_code  = rsc_pkg::DIV_CODE_2;
         new_shift = 2'd1;
      end else if (req_data.target_rate_hz >= rsc_pkg::FLOOR_DIV_4) begin
         new_code  = rsc_pkg::DIV_CODE_4;
         new_shift = 2'd2;
      end else begin
         supported = 1'b0;
      end
   end

   assign scaled   = {2'b00, req_data.target_rate_hz} << new_shift;
   assign new_idx  = rsc_pkg::round_idx(scaled);
   assign new_rate = rsc_pkg::freq_rate(new_idx) >> new_shift;

   always_comb begin
      cur_known = 1'b1;
      cur_shift = 2'd0;
      case (cur_div_ff)
         rsc_pkg::DIV_CODE_1: cur_shift = 2'd0;
         rsc_pkg::DIV_CODE_2: cur_shift = 2'd1;
         rsc_pkg::DIV_CODE_4: cur_shift = 2'd2;
         default:             cur_known = 1'b0;
      endcase
   end

   assign cur_rate   = cur_known ? (rsc_pkg::freq_rate(cur_idx_ff) >> cur_shift) : 31'd0;
   assign count_next = wait_count_ff + 16'd1;

   always_comb begin
      timeout_in    = csr_valid ? csr_wdata : timeout_ff;
      waiting_in    = waiting_ff;
      wait_count_in = wait_count_ff;
      cur_div_in    = cur_div_ff;
      cur_idx_in    = cur_idx_ff;
      pend_div_in   = pend_div_ff;
      pend_late_in  = pend_late_ff;
      pend_rate_in  = pend_rate_ff;

      q_push          = 1'b0;
      q_job.op        = rsc_pkg::JOB_SINGLE;
      q_job.kind      = rsc_pkg::KIND_DONE;
      q_job.status    = rsc_pkg::STATUS_OK;
      q_job.rate      = 31'd0;
      q_job.div_write = 1'b0;
      q_job.div_code  = new_code;
      q_job.freq_word = rsc_pkg::freq_word(new_idx);

      if (accept) begin
         if (req_data.command == rsc_pkg::CMD_TICK) begin
            if (waiting_ff && req_data.lock_seen) begin
               waiting_in      = 1'b0;
               pend_late_in    = 1'b0;
               if (pend_late_ff) cur_div_in = pend_div_ff;
               q_push          = 1'b1;
               q_job.op        = rsc_pkg::JOB_LOCK;
               q_job.rate      = pend_rate_ff;
               q_job.div_write = pend_late_ff;
               q_job.div_code  = pend_div_ff;
            end else if (waiting_ff) begin
               wait_count_in = count_next;
               if (count_next >= timeout_ff) begin
                  waiting_in   = 1'b0;
                  pend_late_in = 1'b0;
                  q_push       = 1'b1;
                  q_job.status = rsc_pkg::STATUS_TIMEOUT;
               end
            end
         end else if (waiting_ff) begin
            q_push       = 1'b1;
            q_job.status = rsc_pkg::STATUS_BUSY;
         end else if (req_data.command == rsc_pkg::CMD_READ) begin
            q_push     = 1'b1;
            q_job.kind = rsc_pkg::KIND_RATE;
            q_job.rate = cur_rate;
         end else if (!supported) begin
            q_push       = 1'b1;
            q_job.kind   = (req_data.command == rsc_pkg::CMD_QUERY) ?
                           rsc_pkg::KIND_RATE : rsc_pkg::KIND_DONE;
            q_job.status = rsc_pkg::STATUS_UNSUPPORTED;
         end else if (req_data.command == rsc_pkg::CMD_QUERY) begin
            q_push     = 1'b1;
            q_job.kind = rsc_pkg::KIND_RATE;
            q_job.rate = new_rate;
         end else begin
            // set: an unknown current divider counts as unchanged
            q_push          = 1'b1;
            q_job.op        = rsc_pkg::JOB_SET;
            q_job.div_write = cur_known && (new_shift > cur_shift);
            if (cur_known && (new_shift > cur_shift)) cur_div_in = new_code;
            cur_idx_in    = new_idx;
            waiting_in    = 1'b1;
            wait_count_in = 16'd0;
            pend_div_in   = new_code;
            pend_late_in  = cur_known && (new_shift < cur_shift);
            pend_rate_in  = new_rate;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= rsc_pkg::TIMEOUT_RESET;
         waiting_ff    <= 1'b0;
         wait_count_ff <= 16'd0;
         cur_div_ff    <= rsc_pkg::DIV_CODE_1;
         cur_idx_ff    <= rsc_pkg::FREQ_IDX_RESET;
         pend_div_ff   <= rsc_pkg::DIV_CODE_1;
         pend_late_ff  <= 1'b0;
         pend_rate_ff  <= 31'd0;
      end else begin
         timeout_ff    <= timeout_in;
         waiting_ff    <= waiting_in;
         wait_count_ff <= wait_count_in;
         cur_div_ff    <= cur_div_in;
         cur_idx_ff    <= cur_idx_in;
         pend_div_ff   <= pend_div_in;
         pend_late_ff  <= pend_late_in;
         pend_rate_ff  <= pend_rate_in;
      end
   end

endmodule

[rtl/core/rsc_queue.sv]
// Small job queue between front and back end of the rate switch controller.
// Register storage, head visible combinationally. Uses rsc_pkg.
`timescale 1ns / 1ps

module rsc_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsc_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output rsc_pkg::job_type head_job,
   output logic             head_valid
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsc_pkg::job_type slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/rsc_back.sv]
// Back end: expands queued jobs into result transactions, one per cycle while
// the receiver keeps up, into a registered result slot. Uses rsc_pkg.
`timescale 1ns / 1ps

module rsc_back (
   input  logic             clock,
   input  logic             reset,
   input  rsc_pkg::job_type head_job,
   input  logic             head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsc_pkg::rsp_type rsp_data
);

   logic             started_ff, started_in;
   logic [1:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsc_pkg::rsp_type rsp_ff;

   logic             load;
   logic [1:0]       step;
   rsc_pkg::rsp_type item;

   // step 0 is the early/late divider write, skipped when not needed
   assign step = started_ff ? step_ff : (head_job.div_write ? 2'd0 : 2'd1);

   always_comb begin
      item.result_kind = rsc_pkg::KIND_WRITE;
      item.reg_select  = rsc_pkg::REG_DIV;
      item.write_value = {17'd0, head_job.div_code};
      item.rate_hz     = 31'd0;
      item.status      = rsc_pkg::STATUS_OK;
      item.last        = 1'b0;
      case (head_job.op)
         rsc_pkg::JOB_SET: begin
            case (step)
               2'd1: begin
                  item.reg_select  = rsc_pkg::REG_CTRL;
                  item.write_value = rsc_pkg::CTRL_PREPARE;
               end
               2'd2: begin
                  item.reg_select  = rsc_pkg::REG_FREQ;
                  item.write_value = head_job.freq_word;
               end
               2'd3: begin
                  item.reg_select  = rsc_pkg::REG_CTRL;
                  item.write_value = rsc_pkg::CTRL_ENABLE;
                  item.last        = 1'b1;
               end
               default: ;
            endcase
         end
         rsc_pkg::JOB_LOCK: begin
            if (step != 2'd0) begin
               item.result_kind = rsc_pkg::KIND_DONE;
               item.write_value = 19'd0;
               item.rate_hz     = head_job.rate;
               item.last        = 1'b1;
            end
         end
         default: begin
            item.result_kind = head_job.kind;
            item.write_value = 19'd0;
            item.rate_hz     = head_job.rate;
            item.status      = head_job.status;
            item.last        = 1'b1;
         end
      endcase
   end

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && item.last;

   always_comb begin
      started_in   = started_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         started_in   = !item.last;
         step_in      = step + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/tb_cpu_pll_rate_switch_controller.sv]
// Testbench for cpu_pll_rate_switch_controller: queue-fed request driver, response monitor
// and an in-bench rate/divider predictor checked transaction by transaction.
// Depends on rsc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_cpu_pll_rate_switch_controller;

   localparam int CYCLE_LIMIT = 200000;
   localparam int FREQ_SLOTS = 11;
   localparam int LAST_PHASE = 6;
   // per phase: sender idles / receiver idles (bit = phase)
   localparam logic [6:0] SEND_IDLE_PHASES = 7'b1010011;
   localparam logic [6:0] RECV_IDLE_PHASES = 7'b1001111;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rsc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsc_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [15:0]      csr_wdata = '0;

   // synthesizer table: rate and N/F word (N in bits 18:11, F in bits 10:0)
   logic [30:0] freq_rates [0:FREQ_SLOTS-1] = '{
      31'd1000000000, 31'd1100000000, 31'd1200000000, 31'd1300000000,
      31'd1400000000, 31'd1500000000, 31'd1600000000, 31'd1800000000,
      31'd1200000000, 31'd1300000000, 31'd1503000000};
   logic [18:0] freq_words [0:FREQ_SLOTS-1] = '{
      19'((34 << 11) | 75),   19'((37 << 11) | 1517), 19'((41 << 11) | 910),
      19'((45 << 11) | 303),  19'((48 << 11) | 1745), 19'((52 << 11) | 1137),
      19'((56 << 11) | 531),  19'((63 << 11) | 1365), 19'((41 << 11) | 1024),
      19'((45 << 11) | 1024), 19'((48 << 11) | 1744)};
   // divider slot i divides by 1 << i
   logic [1:0] div_codes [0:2] = '{rsc_pkg::DIV_CODE_1, rsc_pkg::DIV_CODE_2,
                                   rsc_pkg::DIV_CODE_4};

   logic [15:0] phase_timeout [0:LAST_PHASE] = '{16'd2000, 16'd0, 16'd1, 16'd3,
                                                 16'd65535, 16'd5, 16'd2};
   int phase_items [0:LAST_PHASE] = '{0, 40, 70, 70, 60, 80, 70};

   // predicted controller state
   logic        m_waiting;
   logic [15:0] m_wait_ticks;
   logic [1:0]  m_div_code;
   logic [18:0] m_freq_word;
   logic [1:0]  m_late_div_code;
   logic        m_late_write;
   logic [30:0] m_done_rate;
   logic [15:0] m_lock_timeout;

   rsc_pkg::req_type req_backlog [$];
   rsc_pkg::rsp_type switch_results_due [$];

   logic sender_idle = 1'b0;
   logic receiver_idle = 1'b0;
   logic hold_rsp = 1'b0;
   logic stall_start = 1'b0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   cpu_pll_rate_switch_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 200)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic rsc_pkg::rsp_type answer_item(input logic [1:0] kind,
                                                    input logic [30:0] hz,
                                                    input logic [1:0] status);
      rsc_pkg::rsp_type item;
      item = '0;
      item.result_kind = kind;
      item.rate_hz = hz;
      item.status = status;
      return item;
   endfunction

   function automatic rsc_pkg::rsp_type write_item(input logic [1:0] sel,
                                                   input logic [18:0] value);
      rsc_pkg::rsp_type item;
      item = '0;
      item.result_kind = rsc_pkg::KIND_WRITE;
      item.reg_select = sel;
      item.write_value = value;
      return item;
   endfunction

   function automatic int div_slot_by_rate(input logic [31:0] hz);
      if (hz >= rsc_pkg::FLOOR_DIV_1) return 0;
      if (hz >= rsc_pkg::FLOOR_DIV_2) return 1;
      if (hz >= rsc_pkg::FLOOR_DIV_4) return 2;
      return -1;
   endfunction

   function automatic int div_slot_by_code(input logic [1:0] code);
      int i;
      for (i = 0; i < 3; i++)
         if (div_codes[i] == code) return i;
      return -1;
   endfunction

   // exact match takes the first hit; otherwise closest entry below, first one on a tie
   function automatic int freq_slot_by_rate(input logic [63:0] hz);
      int i;
      int best;
      logic [63:0] best_hz;
      logic [63:0] r;
      best = -1;
      best_hz = '0;
      for (i = 0; i < FREQ_SLOTS; i++) begin
         r = 64'(freq_rates[i]);
         if (r == hz) return i;
         if (r < hz && (hz - best_hz) > (hz - r)) begin
            best_hz = r;
            best = i;
         end
      end
      return best;
   endfunction

   function automatic int freq_slot_by_word(input logic [18:0] word);
      int i;
      for (i = 0; i < FREQ_SLOTS; i++)
         if (freq_words[i] == word) return i;
      return -1;
   endfunction

   task automatic reset_switch_model();
      m_waiting = 1'b0;
      m_wait_ticks = '0;
      m_div_code = rsc_pkg::DIV_CODE_1;
      m_freq_word = freq_words[0];
      m_late_div_code = rsc_pkg::DIV_CODE_1;
      m_late_write = 1'b0;
      m_done_rate = '0;
      m_lock_timeout = rsc_pkg::TIMEOUT_RESET;
   endtask

   task automatic predict_switch_results(input rsc_pkg::req_type r);
      rsc_pkg::rsp_type res [$];
      rsc_pkg::rsp_type tail;
      int nd;
      int cd;
      int fi;
      logic [30:0] hz;
      if (r.command == rsc_pkg::CMD_TICK) begin
         if (m_waiting) begin
            if (r.lock_seen) begin
               m_waiting = 1'b0;
               // divider shrinks only after the PLL has locked
               if (m_late_write) begin
                  m_div_code = m_late_div_code;
                  res.push_back(write_item(rsc_pkg::REG_DIV, 19'(m_late_div_code)));
               end
               m_late_write = 1'b0;
               res.push_back(answer_item(rsc_pkg::KIND_DONE, m_done_rate,
                                         rsc_pkg::STATUS_OK));
            end else begin
               m_wait_ticks = m_wait_ticks + 16'd1;
               if (m_wait_ticks >= m_lock_timeout) begin
                  m_waiting = 1'b0;
                  m_late_write = 1'b0;
                  res.push_back(answer_item(rsc_pkg::KIND_DONE, '0,
                                            rsc_pkg::STATUS_TIMEOUT));
               end
            end
         end
      end else if (m_waiting) begin
         res.push_back(answer_item(rsc_pkg::KIND_DONE, '0, rsc_pkg::STATUS_BUSY));
      end else if (r.command == rsc_pkg::CMD_READ) begin
         cd = div_slot_by_code(m_div_code);
         fi = freq_slot_by_word(m_freq_word);
         hz = (cd >= 0 && fi >= 0) ? (freq_rates[fi] >> cd) : '0;
         res.push_back(answer_item(rsc_pkg::KIND_RATE, hz, rsc_pkg::STATUS_OK));
      end else begin
         nd = div_slot_by_rate(r.target_rate_hz);
         fi = -1;
         if (nd >= 0)
            fi = freq_slot_by_rate(64'(r.target_rate_hz) << nd);
         if (fi < 0) begin
            res.push_back(answer_item((r.command == rsc_pkg::CMD_QUERY) ?
                                      rsc_pkg::KIND_RATE : rsc_pkg::KIND_DONE,
                                      '0, rsc_pkg::STATUS_UNSUPPORTED));
         end else if (r.command == rsc_pkg::CMD_QUERY) begin
            res.push_back(answer_item(rsc_pkg::KIND_RATE, freq_rates[fi] >> nd,
                                      rsc_pkg::STATUS_OK));
         end else begin
            cd = div_slot_by_code(m_div_code);
            if (cd < 0)
               cd = nd;
            // divider grows before the PLL moves
            if (nd > cd) begin
               m_div_code = div_codes[nd];
               res.push_back(write_item(rsc_pkg::REG_DIV, 19'(div_codes[nd])));
            end
            res.push_back(write_item(rsc_pkg::REG_CTRL, rsc_pkg::CTRL_PREPARE));
            res.push_back(write_item(rsc_pkg::REG_FREQ, freq_words[fi]));
            res.push_back(write_item(rsc_pkg::REG_CTRL, rsc_pkg::CTRL_ENABLE));
            m_freq_word = freq_words[fi];
            m_waiting = 1'b1;
            m_wait_ticks = '0;
            m_late_div_code = div_codes[nd];
            m_late_write = (nd < cd);
            m_done_rate = freq_rates[fi] >> nd;
         end
      end
      if (res.size() > 0) begin
         tail = res.pop_back();
         tail.last = 1'b1;
         res.push_back(tail);
         foreach (res[i])
            switch_results_due.push_back(res[i]);
      end
   endtask

   task automatic check_result(input rsc_pkg::rsp_type got);
      rsc_pkg::rsp_type want;
      if (switch_results_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d status %0d",
                                   got.result_kind, got.status));
         return;
      end
      want = switch_results_due.pop_front();
      if (got.result_kind != want.result_kind)
         report_mismatch($sformatf("result_kind got %0d want %0d",
                                   got.result_kind, want.result_kind));
      if (got.reg_select != want.reg_select)
         report_mismatch($sformatf("reg_select got %0d want %0d",
                                   got.reg_select, want.reg_select));
      if (got.write_value != want.write_value)
         report_mismatch($sformatf("write_value got 0x%0h want 0x%0h",
                                   got.write_value, want.write_value));
      if (got.rate_hz != want.rate_hz)
         report_mismatch($sformatf("rate_hz got %0d want %0d", got.rate_hz, want.rate_hz));
      if (got.status != want.status)
         report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last != want.last)
         report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            predict_switch_results(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data <= req_backlog.pop_front();
               req_valid <= 1'b1;
               send_gap = sender_idle ? $urandom_range(0, 12) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
            recv_gap = receiver_idle ? $urandom_range(0, 12) : 0;
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long receiver stall so the block backs up into the request side
   initial begin
      wait (stall_start);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic queue_req(input logic [1:0] cmd, input logic [31:0] hz, input logic lock);
      rsc_pkg::req_type r;
      r.command = cmd;
      r.target_rate_hz = hz;
      r.lock_seen = lock;
      req_backlog.push_back(r);
   endtask

   function automatic logic [31:0] pick_target();
      logic [31:0] base;
      base = 32'(freq_rates[$urandom_range(0, FREQ_SLOTS - 1)] >> $urandom_range(0, 2));
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return base;
         2: return base + $urandom_range(0, 2) - 1;
         3: return $urandom_range(0, rsc_pkg::FLOOR_DIV_4 - 1);
         4: begin
            case ($urandom_range(0, 2))
               0: base = rsc_pkg::FLOOR_DIV_1;
               1: base = rsc_pkg::FLOOR_DIV_2;
               default: base = rsc_pkg::FLOOR_DIV_4;
            endcase
            return base + $urandom_range(0, 2) - 1;
         end
         default: return $urandom_range(rsc_pkg::FLOOR_DIV_4, 32'd2000000000);
      endcase
   endfunction

   // mostly set / tick / lock sequences with random content, plus loose commands
   task automatic add_random_items(input int count);
      int added;
      int k;
      added = 0;
      while (added < count) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               queue_req(rsc_pkg::CMD_QUERY, pick_target(), 1'($urandom_range(0, 1)));
               added++;
            end
            2: begin
               queue_req(rsc_pkg::CMD_READ, $urandom(), 1'($urandom_range(0, 1)));
               added++;
            end
            3: begin
               queue_req(rsc_pkg::CMD_TICK, $urandom(), 1'($urandom_range(0, 1)));
               added++;
            end
            default: begin
               queue_req(rsc_pkg::CMD_SET, pick_target(), 1'($urandom_range(0, 1)));
               added++;
               k = $urandom_range(0, 6);
               repeat (k) begin
                  if ($urandom_range(0, 3) == 0)
                     queue_req(2'($urandom_range(rsc_pkg::CMD_QUERY, rsc_pkg::CMD_SET)),
                               pick_target(), 1'($urandom_range(0, 1)));
                  else
                     queue_req(rsc_pkg::CMD_TICK, $urandom(), 1'b0);
                  added++;
               end
               if ($urandom_range(0, 3) != 0) begin
                  queue_req(rsc_pkg::CMD_TICK, $urandom(), 1'b1);
                  added++;
               end
            end
         endcase
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || switch_results_due.size() != 0);
   endtask

   // leave the block idle: nothing in flight and no set waiting for lock
   task automatic settle_block();
      drain();
      if (m_waiting) begin
         queue_req(rsc_pkg::CMD_TICK, '0, 1'b1);
         drain();
      end
      repeat (16) @(negedge clock);
   endtask

   task automatic write_lock_timeout(input logic [15:0] ticks);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= ticks;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      m_lock_timeout = ticks;
   endtask

   initial begin
      int ph;
      reset_switch_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idle = SEND_IDLE_PHASES[0];
      receiver_idle = RECV_IDLE_PHASES[0];

      // rounding edges, busy handling, divider ordering at reset timeout
      queue_req(rsc_pkg::CMD_READ, '0, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd0, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd249999999, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd250000000, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd499999999, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd500000000, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd999999999, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd1200000000, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd1502999999, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd1503000000, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'hffffffff, 1'b1);
      queue_req(rsc_pkg::CMD_SET, 32'd0, 1'b0);
      queue_req(rsc_pkg::CMD_TICK, '0, 1'b1);
      queue_req(rsc_pkg::CMD_SET, 32'd375750000, 1'b0);
      queue_req(rsc_pkg::CMD_QUERY, 32'd1000000000, 1'b0);
      queue_req(rsc_pkg::CMD_READ, '0, 1'b0);
      queue_req(rsc_pkg::CMD_SET, 32'd1000000000, 1'b0);
      queue_req(rsc_pkg::CMD_TICK, '0, 1'b0);
      queue_req(rsc_pkg::CMD_TICK, '0, 1'b1);
      queue_req(rsc_pkg::CMD_READ, '0, 1'b0);
      queue_req(rsc_pkg::CMD_SET, 32'd1800000000, 1'b0);
      queue_req(rsc_pkg::CMD_TICK, 32'hffffffff, 1'b1);
      queue_req(rsc_pkg::CMD_SET, 32'd600000000, 1'b0);
      queue_req(rsc_pkg::CMD_TICK, '0, 1'b1);

      for (ph = 1; ph <= LAST_PHASE; ph++) begin
         settle_block();
         write_lock_timeout(phase_timeout[ph]);
         @(negedge clock);
         sender_idle = SEND_IDLE_PHASES[ph];
         receiver_idle = RECV_IDLE_PHASES[ph];
         if (ph == 1) begin
            // zero timeout: first unlocked tick times out, late divider never written
            queue_req(rsc_pkg::CMD_SET, 32'd1000000000, 1'b0);
            queue_req(rsc_pkg::CMD_TICK, '0, 1'b0);
            queue_req(rsc_pkg::CMD_READ, '0, 1'b0);
         end
         add_random_items(phase_items[ph]);
         if (ph == 3)
            stall_start = 1'b1;
      end
      settle_block();

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
